### sv/hbbc_pkg.sv
// ----------------------------------------------------------------------------
// Buffer cache package
// Item types, action codes and status codes shared by the buffer cache files.
// ----------------------------------------------------------------------------
package hbbc_pkg;

    // Width of the block number; the modulo unit folds it byte by byte.
    localparam int BLK_W = 32;

    localparam logic [2:0] ACT_READ    = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_RELEASE = 3'd2;
    localparam logic [2:0] ACT_PIN     = 3'd3;
    localparam logic [2:0] ACT_UNPIN   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    localparam logic [7:0] REFS_MAX = 8'd255;

    typedef struct packed {
        logic [2:0]       action;
        logic [7:0]       device_id;
        logic [BLK_W-1:0] block_number;
        logic [4:0]       buffer_index;
        logic [31:0]      now_tick;
    } t_in_item;

    typedef struct packed {
        logic [4:0] slot;
        logic       was_cached;
        logic       disk_read_request;
        logic       disk_write_request;
        logic [1:0] status;
    } t_out_item;

endpackage

### sv/hbbc_if.sv
// ----------------------------------------------------------------------------
// Buffer cache channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface hbbc_in_if import hbbc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hbbc_out_if import hbbc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/hbbc_mod.sv
// ----------------------------------------------------------------------------
// Bucket modulo unit
// Reduces a block number modulo the bucket count in three pipelined steps.
// ----------------------------------------------------------------------------
module hbbc_mod import hbbc_pkg::*; #(
    parameter int NUM_BUCKETS = 13
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [BLK_W-1:0]       i_value,
    output logic                   o_done,
    output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] o_rem
);
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    // Residues of 2^8, 2^16 and 2^24 modulo the bucket count.
    localparam int R1 = 256 % NUM_BUCKETS;
    localparam int R2 = (R1 * R1) % NUM_BUCKETS;
    localparam int R3 = (R2 * R1) % NUM_BUCKETS;
    // Reciprocal scaled by 2^QK, exact for any 16-bit folded sum.
    localparam int QK    = 22;
    localparam int RECIP = ((1 << QK) + NUM_BUCKETS - 1) / NUM_BUCKETS;

    logic [15:0]   r_sum;
    logic [15:0]   r_quo;
    logic [BW-1:0] r_rem;
    logic          r_ph1;
    logic          r_ph2;
    logic          r_done;
    logic [15:0]   fold;
    logic [37:0]   prod;
    logic [15:0]   qn;
    logic [15:0]   diff;

    // Fold the bytes by their residues, then divide by reciprocal multiplication.
    always_comb begin
        fold = 16'(32'(i_value[7:0]) + 32'(i_value[15:8]) * 32'(R1)
                   + 32'(i_value[23:16]) * 32'(R2) + 32'(i_value[31:24]) * 32'(R3));
        prod = 38'(r_sum) * 38'(RECIP);
        qn   = 16'(32'(r_quo) * 32'(NUM_BUCKETS));
        diff = r_sum - qn;
    end

    // Three steps: fold, quotient, remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph1  <= 1'b0;
            r_ph2  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ph1  <= i_start;
            r_ph2  <= r_ph1;
            r_done <= r_ph2;
            if (i_start) begin
                r_sum <= fold;
            end
            if (r_ph1) begin
                r_quo <= 16'(prod >> QK);
            end
            if (r_ph2) begin
                r_rem <= BW'(diff);
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

### sv/hashed_block_buffer_cache.sv
// ----------------------------------------------------------------------------
// Hashed block buffer cache
// Slots in hashed buckets; evicts by oldest tick if own bucket has none free.
// ----------------------------------------------------------------------------
// Request items arrive on i_in and one result item per known action leaves on
// o_out; unknown actions are dropped without a result. Both are valid/ready.
// A read first passes through the bucket modulo unit, then walks the slots of
// its own bucket list. On a miss with no free slot there it scans the other
// buckets, visiting each bucket head, then each slot of its list. The entry
// table is then updated and the result is produced. Write, release, pin and
// unpin go from the taken item straight to the result. The walk reads one
// slot of the entry table per cycle, which sets the read latency.
// The block takes one item at a time; a new item may be accepted while the
// previous result still waits in the output register, and a stalled receiver
// holds the next result in the sequencer until the register frees up.
// Reset puts every slot in bucket zero in descending order, with all counts,
// ticks and valid flags cleared; the block is ready on the next cycle.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache import hbbc_pkg::*; #(
    parameter int NUM_BUFFERS = 32,
    parameter int NUM_BUCKETS = 13
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hbbc_in_if.sink    i_in,
    hbbc_out_if.source o_out
);
    localparam int IW  = $clog2(NUM_BUFFERS + 1);
    localparam int SW  = $clog2(NUM_BUFFERS);
    localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int BW1 = $clog2(NUM_BUCKETS + 1);
    localparam logic [IW-1:0] LINK_NONE = IW'(NUM_BUFFERS);

    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_HIT, S_SCAN_HEAD, S_SCAN, S_UPDATE, S_RESULT
    } t_state;

    // Entry table and bucket heads.
    logic [7:0]    e_dev   [NUM_BUFFERS];
    logic [31:0]   e_blk   [NUM_BUFFERS];
    logic [7:0]    e_refs  [NUM_BUFFERS];
    logic          e_valid [NUM_BUFFERS];
    logic [31:0]   e_tick  [NUM_BUFFERS];
    logic [IW-1:0] e_next  [NUM_BUFFERS];
    logic [IW-1:0] e_prev  [NUM_BUFFERS];
    logic [IW-1:0] b_head  [NUM_BUCKETS];

    t_state        r_state;
    t_in_item      r_req;
    logic [BW-1:0] r_own;
    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_steps;
    logic [IW-1:0] r_found;
    logic [IW-1:0] r_free;
    logic          r_hit;
    logic          r_move;
    logic [BW1-1:0] r_bkt;
    logic [BW-1:0] r_src;
    logic [31:0]   r_best;
    t_out_item     r_res;
    logic          r_ov;
    t_out_item     r_od;

    logic          mod_start;
    logic          mod_done;
    logic [BW-1:0] mod_rem;
    logic [SW-1:0] cur_a;
    logic [SW-1:0] fnd_a;
    logic [SW-1:0] idx_a;
    logic          walk_end;
    logic          idx_bad;
    logic          in_take;
    logic          res_load;
    logic [IW-1:0] f_prev;
    logic [IW-1:0] f_next;
    logic [IW-1:0] own_head;
    t_out_item     n_res;

    hbbc_mod #(.NUM_BUCKETS(NUM_BUCKETS)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (r_req.block_number),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // Address decode for the walk and for the slot named by an item.
    always_comb begin
        cur_a    = r_cur[SW-1:0];
        fnd_a    = r_found[SW-1:0];
        idx_a    = SW'(i_in.data.buffer_index);
        idx_bad  = 32'(i_in.data.buffer_index) >= 32'(NUM_BUFFERS);
        walk_end = (r_cur >= LINK_NONE) || (r_steps == LINK_NONE);
        in_take  = i_in.valid && (r_state == S_IDLE);
        res_load = (r_state == S_RESULT) && (!r_ov || o_out.ready);
        mod_start = (r_state == S_MOD) && (r_cur == '0);
        f_prev   = e_prev[fnd_a];
        f_next   = e_next[fnd_a];
        own_head = b_head[r_own];
    end

    // Result of a write, release, pin or unpin item as it is taken.
    always_comb begin
        n_res      = '0;
        n_res.slot = i_in.data.buffer_index;
        if (i_in.data.action != ACT_READ) begin
            if (idx_bad) begin
                n_res.status = ST_BAD_INDEX;
            end else if (i_in.data.action == ACT_WRITE) begin
                n_res.disk_write_request = 1'b1;
            end else if (i_in.data.action != ACT_PIN && e_refs[idx_a] == '0) begin
                n_res.status = ST_UNDERFLOW;
            end
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

    // Sequencer, entry table updates and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_cur   <= '0;
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                e_dev[i]   <= '0;
                e_blk[i]   <= '0;
                e_refs[i]  <= '0;
                e_valid[i] <= 1'b0;
                e_tick[i]  <= '0;
                e_next[i]  <= (i == 0) ? LINK_NONE : IW'(i - 1);
                e_prev[i]  <= (i + 1 < NUM_BUFFERS) ? IW'(i + 1) : LINK_NONE;
            end
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                b_head[b] <= (b == 0) ? IW'(NUM_BUFFERS - 1) : LINK_NONE;
            end
        end else begin
            // Output register: load a finished result, drop it once taken.
            if (res_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_req <= i_in.data;
                        r_res <= n_res;
                        if (i_in.data.action == ACT_READ) begin
                            r_cur   <= '0;
                            r_state <= S_MOD;
                        end else if (i_in.data.action <= ACT_UNPIN) begin
                            r_state <= S_RESULT;
                            if (!idx_bad) begin
                                if (i_in.data.action == ACT_WRITE) begin
                                    e_tick[idx_a] <= i_in.data.now_tick;
                                end else if (i_in.data.action == ACT_PIN) begin
                                    if (e_refs[idx_a] != REFS_MAX) begin
                                        e_refs[idx_a] <= e_refs[idx_a] + 8'd1;
                                    end
                                end else if (e_refs[idx_a] != '0) begin
                                    e_refs[idx_a] <= e_refs[idx_a] - 8'd1;
                                end
                            end
                        end
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_own   <= mod_rem;
                        r_cur   <= b_head[mod_rem];
                        r_steps <= '0;
                        r_found <= LINK_NONE;
                        r_free  <= LINK_NONE;
                        r_hit   <= 1'b0;
                        r_move  <= 1'b0;
                        r_state <= S_HIT;
                    end else begin
                        r_cur <= LINK_NONE;
                    end
                end
                S_HIT: begin
                    // Own bucket: look for a match, note the first free slot.
                    if (walk_end) begin
                        r_bkt <= '0;
                        if (r_free != LINK_NONE) begin
                            r_found <= r_free;
                            r_state <= S_UPDATE;
                        end else begin
                            r_state <= S_SCAN_HEAD;
                        end
                    end else if (e_dev[cur_a] == r_req.device_id
                                 && e_blk[cur_a] == r_req.block_number) begin
                        r_found <= r_cur;
                        r_hit   <= 1'b1;
                        r_state <= S_UPDATE;
                    end else begin
                        if (e_refs[cur_a] == '0 && r_free == LINK_NONE) begin
                            r_free <= r_cur;
                        end
                        r_cur   <= e_next[cur_a];
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_SCAN_HEAD: begin
                    if (r_bkt == BW1'(NUM_BUCKETS)) begin
                        r_move  <= (r_found != LINK_NONE);
                        r_state <= S_UPDATE;
                    end else if (BW'(r_bkt) == r_own) begin
                        r_bkt <= r_bkt + 1'b1;
                    end else begin
                        r_cur   <= b_head[BW'(r_bkt)];
                        r_steps <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Other buckets: keep the oldest unreferenced slot.
                    if (walk_end) begin
                        r_bkt   <= r_bkt + 1'b1;
                        r_state <= S_SCAN_HEAD;
                    end else begin
                        if (e_refs[cur_a] == '0
                            && (r_found == LINK_NONE || r_best > e_tick[cur_a])) begin
                            r_found <= r_cur;
                            r_src   <= BW'(r_bkt);
                            r_best  <= e_tick[cur_a];
                        end
                        r_cur   <= e_next[cur_a];
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_UPDATE: begin
                    r_state <= S_RESULT;
                    if (r_found == LINK_NONE) begin
                        r_res.status <= ST_NO_FREE;
                        r_res.slot   <= '0;
                    end else begin
                        r_res.slot <= 5'(r_found);
                        if (r_hit) begin
                            if (e_refs[fnd_a] != REFS_MAX) begin
                                e_refs[fnd_a] <= e_refs[fnd_a] + 8'd1;
                            end
                            r_res.was_cached        <= 1'b1;
                            r_res.disk_read_request <= !e_valid[fnd_a];
                        end else begin
                            e_dev[fnd_a]  <= r_req.device_id;
                            e_blk[fnd_a]  <= r_req.block_number;
                            e_refs[fnd_a] <= 8'd1;
                            r_res.disk_read_request <= 1'b1;
                        end
                        e_valid[fnd_a] <= 1'b1;
                        e_tick[fnd_a]  <= r_req.now_tick;
                        // Move an evicted slot to the head of its new bucket.
                        if (r_move) begin
                            if (f_prev < LINK_NONE) begin
                                e_next[f_prev[SW-1:0]] <= f_next;
                            end else begin
                                b_head[r_src] <= f_next;
                            end
                            if (f_next < LINK_NONE) begin
                                e_prev[f_next[SW-1:0]] <= f_prev;
                            end
                            e_next[fnd_a] <= own_head;
                            e_prev[fnd_a] <= LINK_NONE;
                            if (own_head < LINK_NONE) begin
                                e_prev[own_head[SW-1:0]] <= r_found;
                            end
                            b_head[r_own] <= r_found;
                        end
                    end
                end
                S_RESULT: begin
                    if (res_load) begin
                        r_od    <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
